// ----- design/length_prefixed_frame_parser_unit_macros.svh -----
// Assertion macros shared by the frame parser modules
`ifndef LENGTH_PREFIXED_FRAME_PARSER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_UNIT_MACROS_SVH

// condition must never hold
`define LPFP_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

// same-cycle implication
`define LPFP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LPFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lpfp_pkg.sv -----
// Types and codes shared by the frame parser modules
package lpfp_pkg;

    typedef enum logic [1:0] {
        CFG_EXPECTED_VERSION = 2'd0,
        CFG_LOWEST_TYPE      = 2'd1,
        CFG_HIGHEST_TYPE     = 2'd2,
        CFG_MAX_PAYLOAD_LEN  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        HERR_NONE    = 2'd0,
        HERR_VERSION = 2'd1,
        HERR_TYPE    = 2'd2,
        HERR_LENGTH  = 2'd3
    } herr_t;

    typedef enum logic [2:0] {
        WST_INCOMPLETE = 3'd0,
        WST_DONE       = 3'd1,
        WST_VERSION    = 3'd2,
        WST_TYPE       = 3'd3,
        WST_LENGTH     = 3'd4
    } wst_t;

    localparam logic [7:0]  RST_EXPECTED_VERSION = 8'd1;
    localparam logic [7:0]  RST_LOWEST_TYPE      = 8'd1;
    localparam logic [7:0]  RST_HIGHEST_TYPE     = 8'd255;
    localparam logic [15:0] RST_MAX_PAYLOAD_LEN  = 16'd512;

    typedef struct packed {
        logic [7:0]  expected_version;
        logic [7:0]  lowest_type;
        logic [7:0]  highest_type;
        logic [15:0] max_payload_len;
    } cfg_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        logic        frame_done;
        logic [7:0]  frame_type;
        logic [15:0] frame_length;
        logic [1:0]  header_error;
        logic        status_valid;
        logic [2:0]  write_status;
    } result_t;

endpackage

// ----- design/lpfp_parser.sv -----
// Front end: accepts stream words, parses headers and classifies each byte
module lpfp_parser import lpfp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_write,
    input  logic       q_space,
    output logic       q_push,
    output result_t    q_data
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_SKIP    = 3'b100
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  hcount_reg, hcount_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] remain_reg, remain_next;
    logic [2:0]  first_err_reg, first_err_next;
    logic        seen_reg, seen_next;

    logic        fire;
    logic [15:0] hdr_len;
    logic [15:0] remain_dec;
    logic [1:0]  herr;
    logic        boundary;
    result_t     res;

    assign s_ready = q_space;
    assign fire    = s_valid && q_space;
    assign q_push  = fire;
    assign q_data  = res;

    assign hdr_len    = {length_reg[15:8], s_in_byte};
    assign remain_dec = remain_reg - 16'd1;

    always_comb begin
        phase_next     = phase_reg;
        hcount_next    = hcount_reg;
        version_next   = version_reg;
        type_next      = type_reg;
        length_next    = length_reg;
        remain_next    = remain_reg;
        first_err_next = first_err_reg;
        seen_next      = seen_reg;
        res            = '0;
        herr           = HERR_NONE;
        boundary       = 1'b0;

        unique case (phase_reg)
            PH_PAYLOAD: begin
                res.payload_valid = 1'b1;
                res.payload_byte  = s_in_byte;
                res.payload_index = length_reg - remain_reg;
                res.frame_type    = type_reg;
                res.frame_length  = length_reg;
                remain_next       = remain_dec;
                if (remain_dec == 16'd0) begin
                    res.frame_done = 1'b1;
                    seen_next      = 1'b1;
                    phase_next     = PH_HEADER;
                    hcount_next    = 2'd0;
                end
            end
            PH_SKIP: begin
                remain_next = remain_dec;
                if (remain_dec == 16'd0) begin
                    phase_next = PH_HEADER;
                end
            end
            default: begin
                unique case (hcount_reg)
                    2'd0: version_next = s_in_byte;
                    2'd1: type_next = s_in_byte;
                    2'd2: length_next = {s_in_byte, 8'd0};
                    default: length_next = hdr_len;
                endcase
                hcount_next = hcount_reg + 2'd1;
                if (hcount_reg == 2'd3) begin
                    priority if (version_reg != cfg.expected_version) begin
                        herr = HERR_VERSION;
                    end else if (type_reg < cfg.lowest_type
                                 || type_reg > cfg.highest_type) begin
                        herr = HERR_TYPE;
                    end else if (hdr_len > cfg.max_payload_len) begin
                        herr = HERR_LENGTH;
                    end else begin
                        herr = HERR_NONE;
                    end
                    res.header_error = herr;
                    if (herr != HERR_NONE) begin
                        if (first_err_reg == WST_INCOMPLETE) begin
                            first_err_next = {1'b0, herr} + 3'd1;
                        end
                        remain_next = hdr_len;
                        phase_next  = (hdr_len != 16'd0) ? PH_SKIP : PH_HEADER;
                    end else if (hdr_len == 16'd0) begin
                        res.frame_done = 1'b1;
                        res.frame_type = type_reg;
                        seen_next      = 1'b1;
                    end else begin
                        remain_next = hdr_len;
                        phase_next  = PH_PAYLOAD;
                    end
                end
            end
        endcase

        if (s_end_of_write) begin
            res.status_valid = 1'b1;
            boundary = (phase_next == PH_SKIP)
                       || (phase_next == PH_HEADER && hcount_next == 2'd0);
            if (first_err_next != WST_INCOMPLETE) begin
                res.write_status = first_err_next;
            end else begin
                res.write_status = (boundary && seen_next) ? WST_DONE : WST_INCOMPLETE;
            end
            if (phase_next == PH_SKIP) begin
                phase_next  = PH_HEADER;
                remain_next = 16'd0;
            end
            first_err_next = WST_INCOMPLETE;
            seen_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            hcount_reg    <= 2'd0;
            version_reg   <= 8'd0;
            type_reg      <= 8'd0;
            length_reg    <= 16'd0;
            remain_reg    <= 16'd0;
            first_err_reg <= WST_INCOMPLETE;
            seen_reg      <= 1'b0;
        end else if (fire) begin
            phase_reg     <= phase_next;
            hcount_reg    <= hcount_next;
            version_reg   <= version_next;
            type_reg      <= type_next;
            length_reg    <= length_next;
            remain_reg    <= remain_next;
            first_err_reg <= first_err_next;
            seen_reg      <= seen_next;
        end
    end

`include "length_prefixed_frame_parser_unit_macros.svh"

    `LPFP_ASSERT_NEVER(a_remain_nonzero, (phase_reg != PH_HEADER) && (remain_reg == 16'd0), "payload or skip phase with nothing remaining")
    `LPFP_ASSERT_NEVER(a_hcount_outside_header, (phase_reg != PH_HEADER) && (hcount_reg != 2'd0), "header count nonzero outside header phase")
    `LPFP_ASSERT_NEXT(a_done_returns_header, fire && res.frame_done, phase_reg == PH_HEADER, "frame completion did not return to header phase")

endmodule

// ----- design/lpfp_queue.sv -----
// Back end: two-entry result queue driving the result channel
module lpfp_queue import lpfp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_data
);

    result_t    entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign space   = (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign pop     = m_valid && m_ready;
    assign m_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

`include "length_prefixed_frame_parser_unit_macros.svh"

    `LPFP_ASSERT_NEVER(a_count_range, count_reg == 2'd3, "queue count out of range")
    `LPFP_ASSERT_NEVER(a_push_full, push && (count_reg == 2'd2), "push into full queue")
    `LPFP_ASSERT_IMPL(a_ptr_count, (count_reg == 2'd0) || (count_reg == 2'd2), wr_ptr_reg == rd_ptr_reg, "pointers disagree with count")

endmodule

// ----- design/length_prefixed_frame_parser_unit.sv -----
// Top level of the length-prefixed frame parser
//
// Input channel (s_*): one stream byte per word plus an end-of-write flag.
// Result channel (m_*): exactly one result word per input word, in order:
//   payload pass-through with index, frame completion, header verdict on
//   the fourth header byte, and a write status on the last byte of a write.
// Configuration: cfg_wr_en writes cfg_wr_data to register cfg_wr_index
//   (0 expected version, 1 lowest type, 2 highest type, 3 max payload
//   length); write only while the block is idle.
// Output: each result is registered in the queue before m_valid offers it.
// Throughput: one byte per cycle while the queue has space, set by the parse
//   step and the two-entry result queue.
// Reset (aresetn low, synchronous): registers return to defaults, the
//   parser goes to the start of a header and the queue empties.
// Receiver stall: the queue holds up to two results; s_ready drops only
//   when both entries are occupied.
module length_prefixed_frame_parser_unit import lpfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_end_of_write,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_payload_valid,
    output logic [7:0]  m_payload_byte,
    output logic [15:0] m_payload_index,
    output logic        m_frame_done,
    output logic [7:0]  m_frame_type,
    output logic [15:0] m_frame_length,
    output logic [1:0]  m_header_error,
    output logic        m_status_valid,
    output logic [2:0]  m_write_status
);

    cfg_t    cfg_reg;
    logic    q_space;
    logic    q_push;
    result_t q_data;
    result_t m_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.expected_version <= RST_EXPECTED_VERSION;
            cfg_reg.lowest_type      <= RST_LOWEST_TYPE;
            cfg_reg.highest_type     <= RST_HIGHEST_TYPE;
            cfg_reg.max_payload_len  <= RST_MAX_PAYLOAD_LEN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_EXPECTED_VERSION: cfg_reg.expected_version <= cfg_wr_data[7:0];
                CFG_LOWEST_TYPE:      cfg_reg.lowest_type      <= cfg_wr_data[7:0];
                CFG_HIGHEST_TYPE:     cfg_reg.highest_type     <= cfg_wr_data[7:0];
                CFG_MAX_PAYLOAD_LEN:  cfg_reg.max_payload_len  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    lpfp_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_write (s_end_of_write),
        .q_space        (q_space),
        .q_push         (q_push),
        .q_data         (q_data)
    );

    lpfp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .space     (q_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_payload_valid = m_data.payload_valid;
    assign m_payload_byte  = m_data.payload_byte;
    assign m_payload_index = m_data.payload_index;
    assign m_frame_done    = m_data.frame_done;
    assign m_frame_type    = m_data.frame_type;
    assign m_frame_length  = m_data.frame_length;
    assign m_header_error  = m_data.header_error;
    assign m_status_valid  = m_data.status_valid;
    assign m_write_status  = m_data.write_status;

endmodule
